### hw/rtl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// shared types and codes for the indexed shift list: command and status
// codes, request and response words, and the control word fed to every cell
// ----------------------------------------------------------------------------
package isl_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned POS_W   = 4;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_POP_BACK   = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_INSERT     = 3'd4,
      CMD_REMOVE     = 3'd5
   } isl_cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } isl_status_type;

   // what every cell does this cycle
   typedef enum logic [1:0] {
      OP_HOLD  = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2
   } isl_op_type;

   typedef struct packed {
      isl_cmd_type              cmd;
      logic signed [DATA_W-1:0] value_in;
      logic [POS_W-1:0]         position;
   } isl_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_out;
      isl_status_type           status;
      logic [COUNT_W-1:0]       count;
   } isl_rsp_type;

   typedef struct packed {
      isl_op_type               op;
      logic signed [DATA_W-1:0] word;
   } isl_cell_ctrl_type;

endpackage

### hw/rtl/isl_stream_if.sv
// ----------------------------------------------------------------------------
// isl_stream_if
// valid/ready channel carrying one payload word per handshake
// ----------------------------------------------------------------------------
interface isl_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### hw/rtl/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell
// one list slot: holds a word and moves it with its neighbors when a gap
// opens or closes at or below its own index
// ----------------------------------------------------------------------------
module isl_cell
   import isl_pkg::*;
#(
   parameter int unsigned IW    = 4,
   parameter int unsigned INDEX = 0
) (
   input  logic                     clock,
   input  isl_cell_ctrl_type        ctrl,
   input  logic [IW-1:0]            gap_idx,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data_out,
   output logic signed [DATA_W-1:0] taken_out
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     at_gap;
   logic                     above_gap;

   assign at_gap    = (gap_idx == MY_IDX);
   assign above_gap = (MY_IDX > gap_idx);

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         OP_OPEN: begin
            if (at_gap) begin
               data_in = ctrl.word;
            end else if (above_gap) begin
               data_in = left_data;
            end
         end
         OP_CLOSE: begin
            if (at_gap || above_gap) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign taken_out = at_gap ? data_ff : '0;

endmodule

### hw/rtl/indexed_shift_list.sv
// ----------------------------------------------------------------------------
// indexed_shift_list
// bounded ordered list of signed 32-bit words held in a row of cells; push,
// pop, insert and remove shift the whole row at once, in the accepting cycle
// ----------------------------------------------------------------------------
//
//   channel   dir   word fields                      handshake
//   req_chan  in    cmd, value_in, position          valid / ready
//   rsp_chan  out   value_out, status, count         valid / ready
//
// one command per cycle while results are taken: every cell updates in parallel
// with its neighbors, so a command is done in the cycle it is accepted and its
// result word sits in the output register from the next cycle on
// the result register decides the rate: req_chan.ready is high while that
// register is empty or being drained in the same cycle
// reset clears the element count and the result valid; cell contents stay
// undefined until written and are never read before that
// a stalled result holds the list as it is until the result is taken
//
module indexed_shift_list
   import isl_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   isl_stream_if.sink   req_chan,
   isl_stream_if.source rsp_chan
);

   // index width for cell positions, count width holds DEPTH itself
   localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

   isl_req_type req_word;

   // list state
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // result register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_value_in;
   isl_status_type           rsp_status_ff;
   isl_status_type           rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic [COUNT_W-1:0]       rsp_count_in;

   // command decode
   logic              accept;
   logic              full;
   logic              empty;
   logic              pos_ok;
   isl_op_type        op;
   isl_status_type    status;
   logic [IW-1:0]     gap_idx;
   isl_cell_ctrl_type cell_ctrl;

   // cell row
   logic signed [DATA_W-1:0] cell_data  [DEPTH];
   logic signed [DATA_W-1:0] cell_taken [DEPTH];
   logic signed [DATA_W-1:0] taken_all;

   assign req_word       = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_ok = (CMPW'(req_word.position) < CMPW'(count_ff));

   // pick the cell operation, gap index and status for this command
   always_comb begin
      op      = OP_HOLD;
      status  = ST_OK;
      gap_idx = '0;
      case (req_word.cmd)
         CMD_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op      = OP_OPEN;
               gap_idx = IW'(count_ff);
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               op      = OP_CLOSE;
               gap_idx = IW'(count_ff - 1'b1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op = OP_OPEN;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               op = OP_CLOSE;
            end
         end
         CMD_INSERT: begin
            // range is checked before fullness
            if (!pos_ok) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               op      = OP_OPEN;
               gap_idx = IW'(req_word.position);
            end
         end
         CMD_REMOVE: begin
            if (!pos_ok) begin
               status = ST_RANGE;
            end else begin
               op      = OP_CLOSE;
               gap_idx = IW'(req_word.position);
            end
         end
         default: begin
            // unused codes leave the list alone and report ok
            op = OP_HOLD;
         end
      endcase
   end

   assign cell_ctrl.op   = accept ? op : OP_HOLD;
   assign cell_ctrl.word = req_word.value_in;

   // row of cells, each wired to its neighbors (zero at the left end, itself at the right end)
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      isl_cell #(
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .gap_idx    (gap_idx),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .taken_out  (cell_taken[i])
      );
   end

   // only the cell at the gap index drives a nonzero word
   always_comb begin
      taken_all = '0;
      for (int i = 0; i < DEPTH; i++) begin
         taken_all = taken_all | cell_taken[i];
      end
   end

   // count and result word
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         case (op)
            OP_OPEN:  count_in = CW'(count_ff + 1'b1);
            OP_CLOSE: count_in = CW'(count_ff - 1'b1);
            default:  count_in = count_ff;
         endcase
         rsp_valid_in  = 1'b1;
         rsp_value_in  = (op == OP_CLOSE) ? taken_all : '0;
         rsp_status_in = status;
         rsp_count_in  = COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.payload.value_out = rsp_value_ff;
   assign rsp_chan.payload.status    = rsp_status_ff;
   assign rsp_chan.payload.count     = rsp_count_ff;

   // count never goes past the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond depth");

   // an accepted command always leaves a result word behind
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted command without result");

   // a waiting result reports the count the list really holds
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == COUNT_W'(count_ff)))
      else $error("result count differs from list count");

   // a push that is not rejected grows the list by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && (req_word.cmd == CMD_PUSH_BACK ||
                           req_word.cmd == CMD_PUSH_FRONT))
      |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("push did not grow the list");

   // a failed command never hands out a word
   a_err_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0))
      else $error("word returned on failed command");

endmodule

### tb/indexed_shift_list_tb.sv
// ----------------------------------------------------------------------------
// indexed_shift_list_tb
// self-checking bench for the indexed shift list: directed commands on the
// empty and the full list, then random traffic in grow, shrink and mixed
// phases. A shadow list predicts every result word, which is checked field
// by field. The sender runs in bursts and pauses for full drains, and the
// receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module indexed_shift_list_tb;
   import isl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIST_DEPTH   = 16;
   localparam int unsigned MAX_GAP      = 8;
   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

   localparam logic signed [DATA_W-1:0] WORD_MAX  = 32'h7fff_ffff;
   localparam logic signed [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_ZERO = 32'h0000_0000;
   localparam logic signed [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;

   typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} traffic_bias_type;

   logic clock;
   logic reset;

   isl_stream_if #(.payload_type(isl_req_type)) req_if ();
   isl_stream_if #(.payload_type(isl_rsp_type)) rsp_if ();

   indexed_shift_list #(
      .DEPTH(LIST_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   // shadow copy of the list, advanced once per accepted command word
   logic signed [DATA_W-1:0] list_words [LIST_DEPTH];
   int unsigned              list_len;

   // result words still owed by the block, oldest first
   isl_rsp_type pending_rsps [$];

   int unsigned burst_left;
   int unsigned items_sent;
   int unsigned rsps_checked;
   int unsigned mismatches;
   int unsigned status_tally [4];
   bit          hold_off;

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // shadow list model
   // ------------------------------------------------------------------------

   // make room at idx and drop the word in, later words move up by one
   function automatic void open_slot(input int unsigned idx,
                                     input logic signed [DATA_W-1:0] w);
      for (int unsigned i = list_len; i > idx; i--)
         list_words[i] = list_words[i-1];
      list_words[idx] = w;
      list_len++;
   endfunction

   // lift the word at idx out, later words move down by one
   function automatic logic signed [DATA_W-1:0] take_slot(input int unsigned idx);
      logic signed [DATA_W-1:0] w;
      w = list_words[idx];
      for (int unsigned i = idx; i + 1 < list_len; i++)
         list_words[i] = list_words[i+1];
      list_len--;
      return w;
   endfunction

   // apply one command to the shadow list and return the result it owes
   function automatic isl_rsp_type apply_cmd(input isl_req_type req);
      isl_rsp_type rsp;
      logic        full;
      logic        empty;
      rsp.value_out = WORD_ZERO;
      rsp.status    = ST_OK;
      full  = (list_len >= LIST_DEPTH);
      empty = (list_len == 0);
      case (req.cmd)
         CMD_PUSH_BACK: begin
            if (full) rsp.status = ST_FULL;
            else open_slot(list_len, req.value_in);
         end
         CMD_POP_BACK: begin
            if (empty) rsp.status = ST_EMPTY;
            else rsp.value_out = take_slot(list_len - 1);
         end
         CMD_PUSH_FRONT: begin
            if (full) rsp.status = ST_FULL;
            else open_slot(0, req.value_in);
         end
         CMD_POP_FRONT: begin
            if (empty) rsp.status = ST_EMPTY;
            else rsp.value_out = take_slot(0);
         end
         CMD_INSERT: begin
            // an index at or past the count is refused before fullness
            if (req.position >= list_len) rsp.status = ST_RANGE;
            else if (full) rsp.status = ST_FULL;
            else open_slot(req.position, req.value_in);
         end
         CMD_REMOVE: begin
            if (req.position >= list_len) rsp.status = ST_RANGE;
            else rsp.value_out = take_slot(req.position);
         end
         default: begin
            // unused codes leave the list alone
         end
      endcase
      rsp.count = list_len[COUNT_W-1:0];
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // sender: bursts of command words with idle gaps in between
   // ------------------------------------------------------------------------

   task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                           input logic signed [DATA_W-1:0] word,
                           input logic [POS_W-1:0] pos);
      isl_req_type req;
      req.cmd      = isl_cmd_type'(cmd);
      req.value_in = word;
      req.position = pos;
      if (burst_left == 0) begin
         // gap with valid low, so valid is never dropped and raised
         // in the same step
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(50, 200);
         else burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid   <= 1'b1;
      req_if.payload <= req;
      do @(posedge clock); while (!req_if.ready);
      // accepted at this edge: the owed result is known right away
      pending_rsps.push_back(apply_cmd(req));
      items_sent++;
   endtask

   // hold the sender back until every owed result word has come out
   task automatic wait_rsps_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return WORD_ZERO;
         3:       return WORD_ONES;
         default: return $urandom;
      endcase
   endfunction

   // mostly an index inside the list, now and then any 4-bit value
   function automatic logic [POS_W-1:0] pick_pos();
      if ($urandom_range(0, 9) == 0 || list_len == 0)
         return POS_W'($urandom_range(0, LIST_DEPTH - 1));
      return POS_W'($urandom_range(0, list_len - 1));
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(input traffic_bias_type bias);
      int unsigned roll;
      int unsigned grow_pct;
      roll = $urandom_range(0, 99);
      if (roll < 3) return (roll == 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
      case (bias)
         BIAS_GROW:   grow_pct = 75;
         BIAS_SHRINK: grow_pct = 25;
         default:     grow_pct = 50;
      endcase
      if ($urandom_range(0, 99) < grow_pct) begin
         case ($urandom_range(0, 3))
            0:       return CMD_PUSH_BACK;
            1:       return CMD_PUSH_FRONT;
            default: return CMD_INSERT;
         endcase
      end
      case ($urandom_range(0, 3))
         0:       return CMD_POP_BACK;
         1:       return CMD_POP_FRONT;
         default: return CMD_REMOVE;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // test tasks
   // ------------------------------------------------------------------------

   // every taking command on an empty list, refused inserts, unused codes
   task automatic test_empty_list();
      send_cmd(CMD_POP_BACK, WORD_ZERO, 4'd0);
      send_cmd(CMD_POP_FRONT, WORD_ONES, 4'd15);
      send_cmd(CMD_REMOVE, WORD_MAX, 4'd15);
      send_cmd(CMD_REMOVE, WORD_MIN, 4'd0);
      send_cmd(CMD_INSERT, WORD_MAX, 4'd0);
      send_cmd(CMD_INSERT, WORD_MIN, 4'd15);
      send_cmd(CMD_UNUSED_A, WORD_ONES, 4'd5);
      send_cmd(CMD_UNUSED_B, WORD_MAX, 4'd10);
   endtask

   // build up to full with extreme words, then hit every full case
   task automatic test_full_list();
      send_cmd(CMD_PUSH_BACK, WORD_MAX, 4'd0);
      send_cmd(CMD_PUSH_BACK, WORD_MIN, 4'd0);
      send_cmd(CMD_PUSH_FRONT, WORD_ZERO, 4'd0);
      send_cmd(CMD_PUSH_FRONT, WORD_ONES, 4'd0);
      send_cmd(CMD_INSERT, 32'h5555_5555, 4'd1);
      send_cmd(CMD_INSERT, 32'haaaa_aaaa, 4'd3);
      send_cmd(CMD_REMOVE, WORD_ZERO, 4'd2);
      // insert at the count itself is refused, there is no append by index
      send_cmd(CMD_INSERT, WORD_ONES, list_len[POS_W-1:0]);
      while (list_len < LIST_DEPTH)
         send_cmd((list_len % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom, 4'd0);
      send_cmd(CMD_PUSH_BACK, WORD_MAX, 4'd0);
      send_cmd(CMD_PUSH_FRONT, WORD_MIN, 4'd0);
      send_cmd(CMD_INSERT, WORD_ONES, 4'd15);
      send_cmd(CMD_REMOVE, WORD_ZERO, 4'd15);
      send_cmd(CMD_POP_BACK, WORD_ZERO, 4'd0);
      send_cmd(CMD_POP_FRONT, WORD_ZERO, 4'd0);
   endtask

   // random commands; the bias flips every few dozen words so the list
   // sweeps between empty and full many times
   task automatic test_random_traffic(input int unsigned n_items);
      traffic_bias_type bias;
      bias = BIAS_MIXED;
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       bias = BIAS_GROW;
               1:       bias = BIAS_SHRINK;
               default: bias = BIAS_MIXED;
            endcase
         end
         send_cmd(pick_cmd(bias), pick_word(), pick_pos());
      end
   endtask

   // receiver holds off for a long stretch while words keep coming, so the
   // result register fills and the input stalls
   task automatic test_backpressure();
      hold_off = 1'b1;
      burst_left = 100;
      for (int unsigned i = 0; i < 24; i++)
         send_cmd(pick_cmd(BIAS_MIXED), pick_word(), pick_pos());
      while (hold_off) @(posedge clock);
   endtask

   // stop sending until the block has handed back everything it owes
   task automatic test_drain_pause();
      wait_rsps_drained();
      test_random_traffic(20);
      wait_rsps_drained();
   endtask

   // ------------------------------------------------------------------------
   // receiver: stalls on a pattern of its own, plus the long hold-off
   // ------------------------------------------------------------------------

   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned stall_phase;
      rsp_if.ready = 1'b0;
      mode         = 0;
      mode_left    = 0;
      stall_phase  = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            stall_phase++;
            case (mode)
               0:       rsp_if.ready <= 1'b1;                       // no stalls
               1:       rsp_if.ready <= ($urandom_range(0, 9) < 6);
               2:       rsp_if.ready <= (stall_phase % 4 == 0);     // one in four
               default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // result checker: each result word against the oldest expectation
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         isl_rsp_type got;
         isl_rsp_type want;
         got = rsp_if.payload;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            $display("%t unexpected result word: expected none, actual value_out %0d %s %0d",
                     $realtime, got.value_out, got.status.name(), got.count);
         end else begin
            want = pending_rsps.pop_front();
            rsps_checked++;
            status_tally[got.status]++;
            if (got.value_out !== want.value_out) begin
               mismatches++;
               $display("%t value_out mismatch: expected %0d actual %0d",
                        $realtime, want.value_out, got.value_out);
            end
            if (got.status !== want.status) begin
               mismatches++;
               $display("%t status mismatch: expected %s actual %0d",
                        $realtime, want.status.name(), got.status);
            end
            if (got.count !== want.count) begin
               mismatches++;
               $display("%t count mismatch: expected %0d actual %0d",
                        $realtime, want.count, got.count);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too many cycles in a row with no handshake on either side
   // ------------------------------------------------------------------------

   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%t watchdog: no handshake for %0d cycles, %0d results owed",
               $realtime, IDLE_LIMIT, pending_rsps.size());
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      list_len       = 0;
      burst_left     = 0;
      items_sent     = 0;
      rsps_checked   = 0;
      mismatches     = 0;
      hold_off       = 1'b0;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_full_list();
      test_random_traffic(600);
      test_backpressure();
      test_drain_pause();
      test_random_traffic(860);

      // let the last words come out, then leave the channels quiet
      wait_rsps_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands, %0d results checked", items_sent, rsps_checked);
      $display("status mix: %0d ok, %0d range, %0d full, %0d empty; %0d mismatches",
               status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_FULL],
               status_tally[ST_EMPTY], mismatches);
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/isl_pkg.sv
hw/rtl/isl_stream_if.sv
hw/rtl/isl_cell.sv
hw/rtl/indexed_shift_list.sv
tb/indexed_shift_list_tb.sv
